// File: rtl/core/packed_sample_block_unpacker_unit_assert.svh
// Assertion macros used by the unpacker top level.
`ifndef PACKED_SAMPLE_BLOCK_UNPACKER_UNIT_ASSERT_SVH
`define PACKED_SAMPLE_BLOCK_UNPACKER_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define PSBU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PSBU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/psbu_pkg.sv
// Shared types and constants of the packed sample block unpacker.
package psbu_pkg;

    localparam int MAX_SAMPLE_BITS_DEF = 20;     // default sample port width
    localparam int RAW_W      = 20;              // widest sample a header selects
    localparam int ACC_W      = 27;              // bit accumulator width
    localparam int CNT_W      = 4;               // results per transaction, 0..8
    localparam int BITS_W     = 5;
    localparam int CODE_W     = 4;

    localparam logic [CODE_W-1:0] CODE_ZERO = 4'd0;
    localparam logic [CODE_W-1:0] CODE_WIDE = 4'd14;
    localparam logic [CODE_W-1:0] CODE_BAD  = 4'd15;
    localparam logic [BITS_W-1:0] WIDE_BITS   = 5'd20;
    localparam logic [BITS_W-1:0] CODE_OFFSET = 5'd3;
    localparam logic [CNT_W-1:0]  BURST_LEN   = 4'd8;

    // Results of one input byte, handed from the decoder to the output stage.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;         // number of results to emit
        logic              zero_burst;  // width-zero block: cnt zero samples
        logic              bad;         // bad header code
        logic [BITS_W-1:0] bits;
        logic [RAW_W-1:0]  s0;
        logic [RAW_W-1:0]  s1;
        logic              last0;
        logic              last1;
    } t_result;

endpackage

// File: rtl/core/psbu_unpack.sv
// Input register, block state and sample extraction for one stream byte.
module psbu_unpack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_stream_byte,
    input  logic                  i_res_take,
    output logic                  o_res_valid,
    output psbu_pkg::t_result     o_res
);
    import psbu_pkg::*;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_payload,  n_in_payload;
    logic [BITS_W-1:0] r_block_width, n_block_width;
    logic [BITS_W-1:0] r_bytes_left,  n_bytes_left;
    logic [ACC_W-1:0]  r_acc,         n_acc;
    logic [BITS_W-1:0] r_held,        n_held;
    logic [2:0]        r_count,       n_count;

    logic              w_take;
    logic [CODE_W-1:0] w_code;
    logic [ACC_W-1:0]  w_acc_in;
    logic [ACC_W-1:0]  w_acc_one;
    logic [BITS_W-1:0] w_held_in;
    logic [BITS_W:0]   w_two_w;
    logic              w_has_one;
    logic              w_has_two;
    logic [BITS_W-1:0] w_bytes_next;
    logic [BITS_W:0]   w_held_two;

    function automatic logic [RAW_W-1:0] sext(input logic [RAW_W-1:0] raw,
                                              input logic [BITS_W-1:0] w);
        logic [RAW_W-1:0] m;
        logic [RAW_W-1:0] v;
        m = ~({RAW_W{1'b1}} << w);
        v = raw & m;
        if ((w != '0) && v[w - 5'd1]) begin
            v = v | ~m;
        end
        return v;
    endfunction

    assign w_take      = r_in_valid && i_res_take;
    assign o_ready     = !r_in_valid || w_take;
    assign o_res_valid = r_in_valid;

    always_comb begin
        n_in_payload  = r_in_payload;
        n_block_width = r_block_width;
        n_bytes_left  = r_bytes_left;
        n_acc         = r_acc;
        n_held        = r_held;
        n_count       = r_count;
        o_res         = '0;

        w_code       = r_in_byte[7:4];
        w_acc_in     = r_acc | (ACC_W'(r_in_byte) << r_held);
        w_held_in    = r_held + 5'd8;
        w_acc_one    = w_acc_in >> r_block_width;
        w_two_w      = {1'b0, r_block_width} << 1;
        w_has_one    = w_held_in >= r_block_width;
        w_has_two    = {1'b0, w_held_in} >= w_two_w;
        w_bytes_next = r_bytes_left - 5'd1;
        w_held_two   = {1'b0, w_held_in} - w_two_w;

        if (!r_in_payload) begin
            n_acc   = '0;
            n_held  = '0;
            n_count = '0;
            case (w_code)
                CODE_BAD: begin
                    n_block_width = '0;
                    o_res.cnt     = CNT_W'(1);
                    o_res.bad     = 1'b1;
                    o_res.last0   = 1'b1;
                end
                CODE_ZERO: begin
                    n_block_width    = '0;
                    o_res.cnt        = BURST_LEN;
                    o_res.zero_burst = 1'b1;
                end
                CODE_WIDE: begin
                    n_block_width = WIDE_BITS;
                    n_bytes_left  = WIDE_BITS;
                    n_in_payload  = 1'b1;
                end
                default: begin
                    n_block_width = BITS_W'(w_code) + CODE_OFFSET;
                    n_bytes_left  = BITS_W'(w_code) + CODE_OFFSET;
                    n_in_payload  = 1'b1;
                end
            endcase
        end else begin
            o_res.bits  = r_block_width;
            o_res.s0    = sext(w_acc_in[RAW_W-1:0], r_block_width);
            o_res.s1    = sext(w_acc_one[RAW_W-1:0], r_block_width);
            o_res.last0 = (r_count == 3'd7);
            o_res.last1 = (r_count == 3'd6);
            if (w_has_two) begin
                o_res.cnt = CNT_W'(2);
                n_acc     = w_acc_one >> r_block_width;
                n_held    = w_held_two[BITS_W-1:0];
                n_count   = r_count + 3'd2;
            end else if (w_has_one) begin
                o_res.cnt = CNT_W'(1);
                n_acc     = w_acc_one;
                n_held    = w_held_in - r_block_width;
                n_count   = r_count + 3'd1;
            end else begin
                n_acc  = w_acc_in;
                n_held = w_held_in;
            end
            n_bytes_left = w_bytes_next;
            if (w_bytes_next == '0) begin
                n_in_payload = 1'b0;
                n_acc        = '0;
                n_held       = '0;
                n_count      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_in_payload  <= 1'b0;
            r_block_width <= '0;
            r_bytes_left  <= '0;
            r_acc         <= '0;
            r_held        <= '0;
            r_count       <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_take) begin
                r_in_payload  <= n_in_payload;
                r_block_width <= n_block_width;
                r_bytes_left  <= n_bytes_left;
                r_acc         <= n_acc;
                r_held        <= n_held;
                r_count       <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_stream_byte;
        end
    end

endmodule

// File: rtl/core/psbu_out.sv
// Result register that emits the results of one byte, one per cycle while i_ready is high.
module psbu_out #(
    parameter int P_MAX_SAMPLE_BITS = psbu_pkg::MAX_SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_res_valid,
    input  psbu_pkg::t_result                i_res,
    output logic                             o_res_take,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [P_MAX_SAMPLE_BITS-1:0] o_sample,
    output logic [psbu_pkg::BITS_W-1:0]      o_sample_bits,
    output logic                             o_last_of_block,
    output logic                             o_bad_header
);
    import psbu_pkg::*;

    localparam int ExtW = (P_MAX_SAMPLE_BITS > RAW_W) ? P_MAX_SAMPLE_BITS : RAW_W;

    t_result          r_res;
    logic [CNT_W-1:0] r_left;
    logic             r_idx;
    logic [RAW_W-1:0] w_raw;
    logic [ExtW-1:0]  w_ext;
    logic             w_can_load;

    assign o_valid    = (r_left != '0);
    assign w_can_load = (r_left == '0) || ((r_left == CNT_W'(1)) && i_ready);
    assign o_res_take = w_can_load;

    assign w_raw           = r_idx ? r_res.s1 : r_res.s0;
    assign w_ext           = ExtW'(signed'(w_raw));
    assign o_sample        = w_ext[P_MAX_SAMPLE_BITS-1:0];
    assign o_sample_bits   = r_res.bits;
    assign o_bad_header    = r_res.bad;
    assign o_last_of_block = r_res.zero_burst ? (r_left == CNT_W'(1))
                                              : (r_idx ? r_res.last1 : r_res.last0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= 1'b0;
        end else if (w_can_load && i_res_valid) begin
            r_left <= i_res.cnt;
            r_idx  <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - CNT_W'(1);
            r_idx  <= !r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/core/packed_sample_block_unpacker_unit.sv
// Top level of the packed sample block unpacker.
//
// Usage: bytes of the packed stream enter on i_valid / o_ready / i_stream_byte.
// A header byte picks the sample width from its top nibble; the payload bytes
// that follow carry eight LSB-first samples. Samples leave on o_valid / i_ready
// with o_sample (sign-extended), o_sample_bits, o_last_of_block, o_bad_header.
// A width-zero header yields eight zero samples; header code 15 yields one
// result with o_bad_header and o_last_of_block set.
// A taken byte is decoded from the input register; its results are loaded into
// the result register as soon as the output stage can take them.
// Throughput: one byte per cycle while each byte yields at most one result and
// i_ready is high. A byte that completes two samples, or a width-zero header,
// holds the decoder: the single result register drains one transaction per
// cycle while i_ready is high, and the decoder hands over only as it empties.
// Reset: synchronous, active low; the block waits for a header, all buffered
// bytes and results are dropped.
// Stall: while i_ready is low the result register holds; one more byte is
// still taken into the input register, after which o_ready falls.
`include "packed_sample_block_unpacker_unit_assert.svh"

module packed_sample_block_unpacker_unit #(
    parameter int P_MAX_SAMPLE_BITS = psbu_pkg::MAX_SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_stream_byte,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [P_MAX_SAMPLE_BITS-1:0] o_sample,
    output logic [psbu_pkg::BITS_W-1:0]         o_sample_bits,
    output logic                                o_last_of_block,
    output logic                                o_bad_header
);
    import psbu_pkg::*;

    t_result w_res;         // decoded results of the byte in the input register
    logic    w_res_valid;
    logic    w_res_take;    // output stage can load a new transaction

    // Input register, block state, sample extraction.
    psbu_unpack u_unpack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_stream_byte (i_stream_byte),
        .i_res_take    (w_res_take),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // Result register; emits up to eight results per byte.
    psbu_out #(
        .P_MAX_SAMPLE_BITS (P_MAX_SAMPLE_BITS)
    ) u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res_valid     (w_res_valid),
        .i_res           (w_res),
        .o_res_take      (w_res_take),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample        (o_sample),
        .o_sample_bits   (o_sample_bits),
        .o_last_of_block (o_last_of_block),
        .o_bad_header    (o_bad_header)
    );

    // A bad header result always closes its block and carries no width.
    `PSBU_ASSERT(a_bad_is_last, o_valid && o_bad_header |-> o_last_of_block && (o_sample_bits == '0), "bad header result without last flag")

    // Width-zero results carry a zero sample.
    `PSBU_ASSERT(a_zero_width_sample, o_valid && (o_sample_bits == '0) |-> (o_sample == '0), "nonzero sample in zero-width result")

    // A zero burst runs without gaps until its last sample.
    `PSBU_ASSERT(a_zero_burst_cont, o_valid && i_ready && (o_sample_bits == '0) && !o_last_of_block |=> o_valid && (o_sample_bits == '0), "zero burst interrupted")

endmodule

// File: verif/tb.sv
// Self-checking testbench of the packed sample block unpacker.
`timescale 1ns / 1ps

module tb;
    import psbu_pkg::*;

    localparam int SMP_W     = MAX_SAMPLE_BITS_DEF;
    localparam int RAND_MIN  = 190;   // minimum number of random bytes to send
    localparam int HOLD_AT   = 60;    // samples seen before the long receiver hold
    localparam int HOLD_LEN  = 300;   // cycles the receiver holds off
    localparam int DRAIN_CYC = 20;    // quiet cycles after the last expected sample

    // One expected output transaction.
    typedef struct packed {
        logic [SMP_W-1:0]  sample;
        logic [BITS_W-1:0] bits;
        logic              eob;
        logic              bad;
    } sample_rec_t;

    // Directed stimulus row; typed rows carry a hand-written expectation:
    // n_res results, all with the given fields, eob only on the final one.
    typedef struct packed {
        logic [7:0]        stream_byte;
        logic              typed;
        logic [3:0]        n_res;
        logic [SMP_W-1:0]  sample;
        logic [BITS_W-1:0] bits;
        logic              eob;
        logic              bad;
    } stim_row_t;

    localparam int N_DIR = 28;
    localparam stim_row_t DIR_TAB [N_DIR] = '{
        // width-zero header, lowest byte: eight zero samples
        '{8'h00, 1'b1, 4'd8, 20'h00000, 5'd0,  1'b1, 1'b0},
        // code fifteen, highest byte: one error result
        '{8'hFF, 1'b1, 4'd1, 20'h00000, 5'd0,  1'b1, 1'b1},
        // 4-bit block of all ones: two -1 samples per byte
        '{8'h10, 1'b1, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hFF, 1'b1, 4'd2, 20'hFFFFF, 5'd4,  1'b0, 1'b0},
        '{8'hFF, 1'b1, 4'd2, 20'hFFFFF, 5'd4,  1'b0, 1'b0},
        '{8'hFF, 1'b1, 4'd2, 20'hFFFFF, 5'd4,  1'b0, 1'b0},
        '{8'hFF, 1'b1, 4'd2, 20'hFFFFF, 5'd4,  1'b1, 1'b0},
        // 20-bit block: max, min, -1, 0, 1, -2, alternating patterns
        '{8'hE0, 1'b1, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hFF, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hFF, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h07, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h00, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h80, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hFF, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hFF, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h0F, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h00, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h00, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h01, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h00, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hE0, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hFF, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hFF, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h55, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'h55, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hA5, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hAA, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0},
        '{8'hAA, 1'b0, 4'd0, 20'h00000, 5'd0,  1'b0, 1'b0}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [7:0]               i_stream_byte = 8'h00;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [SMP_W-1:0]  o_sample;
    logic [BITS_W-1:0]        o_sample_bits;
    logic                     o_last_of_block;
    logic                     o_bad_header;

    packed_sample_block_unpacker_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_stream_byte   (i_stream_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample        (o_sample),
        .o_sample_bits   (o_sample_bits),
        .o_last_of_block (o_last_of_block),
        .o_bad_header    (o_bad_header)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Unpacker state mirror
    logic              pay_active = 1'b0;
    logic [BITS_W-1:0] blk_width  = '0;
    logic [4:0]        bytes_left = '0;
    logic [ACC_W-1:0]  acc        = '0;
    logic [4:0]        acc_bits   = '0;
    logic [2:0]        blk_samples = '0;

    sample_rec_t expected_q [$];   // samples still owed by the DUT
    sample_rec_t step_q [$];       // samples caused by the latest byte

    int  err_cnt = 0;
    int  bytes_sent = 0;
    int  samples_checked = 0;
    int  n_zero_blocks = 0;
    int  n_bad_headers = 0;
    logic [WIDE_BITS:0] widths_seen = '0;
    bit  tx_steady = 1'b0;   // sender offers back to back while set

    // Advance the mirror by one stream byte; the samples it causes go to step_q.
    function automatic void unpack_byte(input logic [7:0] b);
        logic [CODE_W-1:0] code;
        logic [31:0]       mask;
        logic [31:0]       raw;
        sample_rec_t       r;
        int                n;
        code = b[7:4];
        n = 0;
        step_q.delete();
        if (!pay_active) begin
            acc = '0;
            acc_bits = '0;
            blk_samples = '0;
            if (code == CODE_BAD) begin
                blk_width = '0;
                r = '{sample: '0, bits: '0, eob: 1'b1, bad: 1'b1};
                step_q.push_back(r);
                n_bad_headers++;
                return;
            end
            if (code == CODE_ZERO) begin
                blk_width = '0;
                for (int k = 0; k < 8; k++) begin
                    r = '{sample: '0, bits: '0, eob: (k == 7), bad: 1'b0};
                    step_q.push_back(r);
                end
                n_zero_blocks++;
                widths_seen[0] = 1'b1;
                return;
            end
            blk_width = (code == CODE_WIDE) ? WIDE_BITS : {1'b0, code} + CODE_OFFSET;
            widths_seen[blk_width] = 1'b1;
            bytes_left = blk_width;
            pay_active = 1'b1;
            return;
        end

        // payload byte: append above the held bits, then peel whole samples
        acc = acc | ACC_W'(32'(b) << acc_bits);
        acc_bits = acc_bits + 5'd8;
        while (blk_width != 0 && acc_bits >= blk_width && n < 8) begin
            mask = (32'd1 << blk_width) - 32'd1;
            raw = 32'(acc) & mask;
            if (raw[blk_width - 1])
                raw = raw | ~mask;
            r = '{sample: raw[SMP_W-1:0], bits: blk_width,
                  eob: (blk_samples == 3'd7), bad: 1'b0};
            step_q.push_back(r);
            n++;
            acc = acc >> blk_width;
            acc_bits = acc_bits - blk_width;
            blk_samples = blk_samples + 3'd1;
        end
        bytes_left = bytes_left - 5'd1;
        if (bytes_left == 0) begin
            pay_active = 1'b0;
            acc = '0;
            acc_bits = '0;
            blk_samples = '0;
        end
    endfunction

    // Mostly short gaps, some medium, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offer one byte until the transaction completes; mirror advanced at that edge.
    task automatic send_byte(input logic [7:0] b, input bit use_mirror);
        i_valid <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        bytes_sent++;
        unpack_byte(b);
        if (use_mirror)
            foreach (step_q[k])
                expected_q.push_back(step_q[k]);
    endtask

    // Optional idle gap after a transaction; valid only drops if a gap is taken.
    task automatic tx_pause();
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 19))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return CODE_ZERO;
        if (r == 3)
            return CODE_BAD;
        if (r < 6)
            return CODE_WIDE;
        if (r < 8)
            return CODE_W'(1);
        return CODE_W'($urandom_range(1, 13));
    endfunction

    // Stimulus
    initial begin
        sample_rec_t r;
        int          rand_sent;
        int          seg;
        logic [7:0]  hdr;

        rand_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            send_byte(DIR_TAB[i].stream_byte, !DIR_TAB[i].typed);
            if (DIR_TAB[i].typed) begin
                for (int k = 0; k < DIR_TAB[i].n_res; k++) begin
                    r.sample = DIR_TAB[i].sample;
                    r.bits   = DIR_TAB[i].bits;
                    r.eob    = DIR_TAB[i].eob && (k == DIR_TAB[i].n_res - 1);
                    r.bad    = DIR_TAB[i].bad;
                    expected_q.push_back(r);
                end
            end
            tx_pause();
        end

        // sender pause: let every owed sample drain before the random part
        i_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);

        // random part: well-formed blocks with random content, some noise
        while (rand_sent < RAND_MIN) begin
            if ((rand_sent / 40) % 3 == 1)
                tx_steady = 1'b1;
            else
                tx_steady = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                seg = $urandom_range(1, 6);
                repeat (seg) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    rand_sent++;
                    tx_pause();
                end
            end else begin
                hdr = {pick_code(), 4'($urandom_range(0, 15))};
                send_byte(hdr, 1'b1);
                rand_sent++;
                tx_pause();
                while (pay_active) begin
                    send_byte(pick_payload(), 1'b1);
                    rand_sent++;
                    tx_pause();
                end
            end
        end
        i_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Summary: %0d bytes sent, %0d samples checked", bytes_sent, samples_checked);
        $display("  width-zero blocks %0d, bad headers %0d, widths seen mask %b",
                 n_zero_blocks, n_bad_headers, widths_seen);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random backpressure, stretches of none, one long hold-off
    initial begin
        int  gap;
        int  cyc;
        bit  held;
        bit  rx_steady;

        cyc = 0;
        held = 1'b0;
        rx_steady = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            @(posedge i_clk);
            cyc++;
            if (cyc % 100 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
            if (!held && samples_checked >= HOLD_AT) begin
                // long hold while the sender keeps offering: fills the DUT
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if (!rx_steady) begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Output monitor: compare each transaction against the oldest owed sample
    always @(posedge i_clk) begin
        sample_rec_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected sample %h (bits %0d, last %b, bad %b)",
                       o_sample, o_sample_bits, o_last_of_block, o_bad_header);
                err_cnt++;
            end else begin
                e = expected_q.pop_front();
                samples_checked++;
                if (o_sample !== e.sample) begin
                    $error("sample: expected %h, got %h", e.sample, o_sample);
                    err_cnt++;
                end
                if (o_sample_bits !== e.bits) begin
                    $error("sample_bits: expected %0d, got %0d", e.bits, o_sample_bits);
                    err_cnt++;
                end
                if (o_last_of_block !== e.eob) begin
                    $error("last_of_block: expected %b, got %b", e.eob, o_last_of_block);
                    err_cnt++;
                end
                if (o_bad_header !== e.bad) begin
                    $error("bad_header: expected %b, got %b", e.bad, o_bad_header);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $error("timeout with %0d samples still owed", expected_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/psbu_pkg.sv
rtl/core/psbu_unpack.sv
rtl/core/psbu_out.sv
rtl/core/packed_sample_block_unpacker_unit.sv
verif/tb.sv
